FILE: design/rpf_pkg.sv
// Package for the radius pair finder: field widths, command and register codes,
// reset values and the control struct passed from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps

package rpf_pkg;

  // Defaults for the top-level parameters.
  localparam int TARGET_DEPTH_DEF = 32;
  localparam int COORD_BITS_DEF   = 16;

  // Fixed field widths.
  localparam int CMD_W     = 2;
  localparam int DIST_W    = 34;
  localparam int CAP_W     = 16;
  localparam int MC_W      = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 34;

  // Depth of the command queue between front and back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // Input commands as they arrive on the stream.
  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_MAX      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINES     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER_POINT = 2'd2;

  // Register reset values.
  localparam logic [DIST_W-1:0] DIST_MAX_RST      = 34'd65536;
  localparam logic [CAP_W-1:0]  MAX_LINES_RST     = 16'd1000;
  localparam logic [CAP_W-1:0]  MAX_PER_POINT_RST = 16'd1000;

  // Operations that the front end hands to the back end.
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2
  } rpf_op_t;

  // Head of the command queue as seen by the back end.
  typedef struct packed {
    logic    valid;
    rpf_op_t op;
  } rpf_qctl_t;

endpackage

FILE: design/radius_pair_finder.sv
// Radius pair finder top level: configuration registers, front end and back end.
// Path of a query: command queue, sequencer state, store read, squares, sum and compare,
// then the result register. A query holds the scan engine for its N stored targets (one
// store read per cycle unless the output stalls); start and load are done on their pop.
// Reset (rst_n, synchronous): clears counters, queue and control, and sets the
// registers to their defaults; target store contents stay undefined.
`timescale 1ns / 1ps

module radius_pair_finder #(
  parameter int  TARGET_DEPTH = rpf_pkg::TARGET_DEPTH_DEF,
  parameter int  COORD_BITS   = rpf_pkg::COORD_BITS_DEF,
  localparam int IN_DATA_W    = ((3 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_RAW_W    = 8 * COORD_BITS + 2 + rpf_pkg::MC_W + rpf_pkg::CAP_W,
  localparam int OUT_DATA_W   = ((OUT_RAW_W + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // px, py, pz from the lowest bit up
  input  logic [IN_DATA_W-1:0]             in_tdata,
  // cmd
  input  logic [rpf_pkg::CMD_W-1:0]        in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // qx, qy, qz, tx, ty, tz, sq_dist, match_count, total_lines from the lowest bit up
  output logic [OUT_DATA_W-1:0]            out_tdata,
  // is_end
  output logic                             out_tlast,
  input  logic                             cfg_we,
  input  logic [rpf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rpf_pkg::CFG_W-1:0]        cfg_wdata
);
  import rpf_pkg::*;

  localparam int PT_W = 3 * COORD_BITS;
  localparam int SQ_W = 2 * COORD_BITS + 2;

  logic [DIST_W-1:0] dist_max_r;
  logic [CAP_W-1:0]  max_lines_r;
  logic [CAP_W-1:0]  max_per_point_r;

  rpf_qctl_t        q_ctl;
  logic [PT_W-1:0]  q_point;
  logic             q_pop;

  logic [PT_W-1:0]  res_q;
  logic [PT_W-1:0]  res_t;
  logic [SQ_W-1:0]  res_sd;
  logic [MC_W-1:0]  res_mc;
  logic [CAP_W-1:0] res_tl;

  // Configuration registers; writes to unlisted indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_max_r      <= DIST_MAX_RST;
      max_lines_r     <= MAX_LINES_RST;
      max_per_point_r <= MAX_PER_POINT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIST_MAX:      dist_max_r      <= cfg_wdata[DIST_W-1:0];
        CFG_MAX_LINES:     max_lines_r     <= cfg_wdata[CAP_W-1:0];
        CFG_MAX_PER_POINT: max_per_point_r <= cfg_wdata[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  rpf_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_cmd   (in_tuser),
    .in_point (in_tdata[PT_W-1:0]),
    .q_ctl    (q_ctl),
    .q_point  (q_point),
    .q_pop    (q_pop)
  );

  rpf_back #(
    .TARGET_DEPTH (TARGET_DEPTH),
    .COORD_BITS   (COORD_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_ctl         (q_ctl),
    .q_point       (q_point),
    .q_pop         (q_pop),
    .dist_max      (dist_max_r),
    .max_lines     (max_lines_r),
    .max_per_point (max_per_point_r),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_last      (out_tlast),
    .out_q         (res_q),
    .out_t         (res_t),
    .out_sd        (res_sd),
    .out_mc        (res_mc),
    .out_tl        (res_tl)
  );

  // Pack the result beat, padded with zeros to whole bytes.
  assign out_tdata = OUT_DATA_W'({res_tl, res_mc, res_sd, res_t, res_q});

endmodule

FILE: design/rpf_front.sv
// Front end of the radius pair finder: accepts input beats, classifies the
// command and queues the operation with its point for the back end. Uses rpf_pkg.
`timescale 1ns / 1ps

module rpf_front #(
  parameter int COORD_BITS = rpf_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [rpf_pkg::CMD_W-1:0]          in_cmd,
  input  logic [3*COORD_BITS-1:0]            in_point,
  output rpf_pkg::rpf_qctl_t                 q_ctl,
  output logic [3*COORD_BITS-1:0]            q_point,
  input  logic                               q_pop
);
  import rpf_pkg::*;

  localparam int PT_W = 3 * COORD_BITS;

  rpf_op_t           op_q_r [QUEUE_DEPTH];
  logic [PT_W-1:0]   pt_q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   fill_r;
  logic [QPTR_W:0]   fill_nxt;

  rpf_op_t op_cls;
  logic    keep;
  logic    push;
  logic    pop;

  // Map the incoming command to an operation; the unused code is dropped here.
  always_comb begin
    op_cls = OP_START;
    keep   = 1'b0;
    case (in_cmd)
      CMD_START: begin
        op_cls = OP_START;
        keep   = 1'b1;
      end
      CMD_LOAD: begin
        op_cls = OP_LOAD;
        keep   = 1'b1;
      end
      CMD_QUERY: begin
        op_cls = OP_QUERY;
        keep   = 1'b1;
      end
      default: begin
        op_cls = OP_START;
        keep   = 1'b0;
      end
    endcase
  end

  assign in_ready = (fill_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready && keep;
  assign pop      = q_pop && (fill_r != '0);

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      op_q_r[wr_ptr_r] <= op_cls;
      pt_q_r[wr_ptr_r] <= in_point;
    end
  end

  // Queue pointers and fill level.
  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      fill_r <= fill_nxt;
    end
  end

  assign q_ctl.valid = (fill_r != '0);
  assign q_ctl.op    = op_q_r[rd_ptr_r];
  assign q_point     = pt_q_r[rd_ptr_r];

endmodule

FILE: design/rpf_back.sv
// Back end of the radius pair finder: target store, scan sequencer, distance
// pipeline, cap logic and the result register. Uses rpf_pkg.
`timescale 1ns / 1ps

module rpf_back #(
  parameter int TARGET_DEPTH = rpf_pkg::TARGET_DEPTH_DEF,
  parameter int COORD_BITS   = rpf_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rpf_pkg::rpf_qctl_t            q_ctl,
  input  logic [3*COORD_BITS-1:0]       q_point,
  output logic                          q_pop,
  input  logic [rpf_pkg::DIST_W-1:0]    dist_max,
  input  logic [rpf_pkg::CAP_W-1:0]     max_lines,
  input  logic [rpf_pkg::CAP_W-1:0]     max_per_point,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_last,
  output logic [3*COORD_BITS-1:0]       out_q,
  output logic [3*COORD_BITS-1:0]       out_t,
  output logic [2*COORD_BITS+1:0]       out_sd,
  output logic [rpf_pkg::MC_W-1:0]      out_mc,
  output logic [rpf_pkg::CAP_W-1:0]     out_tl
);
  import rpf_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int PT_W  = 3 * C;
  localparam int SQ_W  = 2 * C + 2;
  localparam int CMP_W = (SQ_W > DIST_W) ? SQ_W : DIST_W;
  localparam int IDX_W = (TARGET_DEPTH > 1) ? $clog2(TARGET_DEPTH) : 1;
  localparam int CNT_W = $clog2(TARGET_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_WAIT = 3'b100
  } rpf_state_t;

  rpf_state_t state_r;
  rpf_state_t state_nxt;

  logic [PT_W-1:0]  store_mem [TARGET_DEPTH];
  logic [CNT_W-1:0] tcount_r;
  logic [CAP_W-1:0] lines_r;
  logic [CNT_W-1:0] k_r;
  logic [CNT_W-1:0] idx_r;
  logic [PT_W-1:0]  qpt_r;

  // Pipeline: stage 1 store read, stage 2 squares, stage 3 sum and compare.
  logic             v1_r, e1_r;
  logic [PT_W-1:0]  t1_r;
  logic             v2_r, e2_r;
  logic [PT_W-1:0]  t2_r;
  logic [SQ_W-1:0]  sqx2_r, sqy2_r, sqz2_r;
  logic             v3_r, e3_r, hit3_r;
  logic [PT_W-1:0]  t3_r;
  logic [SQ_W-1:0]  sd3_r;

  // Result register.
  logic             out_valid_r;
  logic             out_last_r;
  logic [PT_W-1:0]  out_q_r;
  logic [PT_W-1:0]  out_t_r;
  logic [SQ_W-1:0]  out_sd_r;
  logic [MC_W-1:0]  out_mc_r;
  logic [CAP_W-1:0] out_tl_r;

  logic adv;
  logic issue;
  logic issue_end;
  logic wr_en;
  logic emit_pair;
  logic emit_end;
  logic under_caps;

  logic [C:0]             dx, dy, dz;
  logic signed [SQ_W-1:0] mx, my, mz;
  logic [SQ_W-1:0]        sd_sum;

  // The pipeline moves whenever the result register is free or being drained.
  assign adv       = !out_valid_r || out_ready;
  assign q_pop     = q_ctl.valid && (state_r == ST_IDLE);
  assign wr_en     = q_pop && (q_ctl.op == OP_LOAD) && (tcount_r < CNT_W'(TARGET_DEPTH));
  assign issue     = adv && (state_r == ST_SCAN);
  assign issue_end = issue && (idx_r == tcount_r);

  // Sequencer state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_pop && (q_ctl.op == OP_QUERY)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue_end) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (adv && emit_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Counters that the commands and the scan keep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      tcount_r <= '0;
      lines_r  <= '0;
      k_r      <= '0;
      idx_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        case (q_ctl.op)
          OP_START: begin
            tcount_r <= '0;
            lines_r  <= '0;
          end
          OP_LOAD: begin
            if (wr_en) begin
              tcount_r <= tcount_r + 1'b1;
            end
          end
          OP_QUERY: begin
            k_r   <= '0;
            idx_r <= '0;
          end
          default: ;
        endcase
      end
      if (issue && !issue_end) begin
        idx_r <= idx_r + 1'b1;
      end
      if (adv && emit_pair) begin
        lines_r <= lines_r + 1'b1;
        k_r     <= k_r + 1'b1;
      end
    end
  end

  // Query point is held for the whole scan.
  always_ff @(posedge clk) begin
    if (q_pop && (q_ctl.op == OP_QUERY)) begin
      qpt_r <= q_point;
    end
  end

  // Target store: written on loads, read once per scan step.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[tcount_r[IDX_W-1:0]] <= q_point;
    end
  end

  always_ff @(posedge clk) begin
    if (issue && !issue_end) begin
      t1_r <= store_mem[idx_r[IDX_W-1:0]];
    end
  end

  // Per-axis differences and their squares.
  always_comb begin
    dx = {t1_r[C-1],   t1_r[C-1:0]}     - {qpt_r[C-1],   qpt_r[C-1:0]};
    dy = {t1_r[2*C-1], t1_r[2*C-1:C]}   - {qpt_r[2*C-1], qpt_r[2*C-1:C]};
    dz = {t1_r[3*C-1], t1_r[3*C-1:2*C]} - {qpt_r[3*C-1], qpt_r[3*C-1:2*C]};
    mx = $signed(dx) * $signed(dx);
    my = $signed(dy) * $signed(dy);
    mz = $signed(dz) * $signed(dz);
  end

  assign sd_sum = sqx2_r + sqy2_r + sqz2_r;

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= (state_r == ST_SCAN);
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      e1_r   <= issue_end;
      e2_r   <= e1_r;
      t2_r   <= t1_r;
      sqx2_r <= mx;
      sqy2_r <= my;
      sqz2_r <= mz;
      e3_r   <= e2_r;
      t3_r   <= t2_r;
      sd3_r  <= sd_sum;
      hit3_r <= (CMP_W'(sd_sum) < CMP_W'(dist_max));
    end
  end

  // A hit only becomes a pair while both caps still leave room.
  assign under_caps = (lines_r < max_lines) && (CAP_W'(k_r) < max_per_point);
  assign emit_pair  = v3_r && !e3_r && hit3_r && under_caps;
  assign emit_end   = v3_r && e3_r;

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= emit_pair || emit_end;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_last_r <= e3_r;
      out_q_r    <= qpt_r;
      if (e3_r) begin
        out_t_r  <= '0;
        out_sd_r <= '0;
        out_mc_r <= MC_W'(k_r);
        out_tl_r <= lines_r;
      end else begin
        out_t_r  <= t3_r;
        out_sd_r <= sd3_r;
        out_mc_r <= '0;
        out_tl_r <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_last  = out_last_r;
  assign out_q     = out_q_r;
  assign out_t     = out_t_r;
  assign out_sd    = out_sd_r;
  assign out_mc    = out_mc_r;
  assign out_tl    = out_tl_r;

endmodule

FILE: sim/radius_pair_finder_tb.sv
// Self-checking testbench for radius_pair_finder: directed cases, then random frames
// under several idling patterns, each result beat checked against an in-bench predictor.
// Depends on rpf_pkg and the radius_pair_finder RTL.
`timescale 1ns / 1ps

module radius_pair_finder_tb;
  import rpf_pkg::*;

  localparam int TGT_DEPTH    = TARGET_DEPTH_DEF;
  localparam int IN_W         = 48;
  localparam int OUT_W        = 152;
  localparam int WATCHDOG_MAX = 4000;
  localparam int DRAIN_CYCLES = 60;
  localparam int PHASE_ITEMS  = 44;

  // Command value the block does not use.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Idling patterns of the two channels.
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // Register settings used by the random phases.
  typedef enum int {SET_WIDE_OPEN, SET_RANDOM_SMALL, SET_CLOSED, SET_RANDOM_MID} setting_t;

  // One result beat: tlast plus the unpacked tdata fields.
  typedef struct packed {
    logic              is_end;
    logic [15:0]       qx, qy, qz;
    logic [15:0]       tx, ty, tz;
    logic [DIST_W-1:0] sq_dist;
    logic [MC_W-1:0]   match_count;
    logic [CAP_W-1:0]  total_lines;
  } pair_result_t;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_tvalid   = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata    = '0;
  logic [CMD_W-1:0]     in_tuser    = CMD_START;
  logic                 out_tvalid;
  logic                 out_tready  = 1'b0;
  logic [OUT_W-1:0]     out_tdata;
  logic                 out_tlast;
  logic                 cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = CFG_DIST_MAX;
  logic [CFG_W-1:0]     cfg_wdata   = '0;

  // Predictor state and register shadows.
  logic signed [15:0] tgt_x [TGT_DEPTH];
  logic signed [15:0] tgt_y [TGT_DEPTH];
  logic signed [15:0] tgt_z [TGT_DEPTH];
  int                 tgt_count   = 0;
  int                 frame_lines = 0;
  logic [DIST_W-1:0]  dist_max_r      = DIST_MAX_RST;
  logic [CAP_W-1:0]   max_lines_r     = MAX_LINES_RST;
  logic [CAP_W-1:0]   max_per_point_r = MAX_PER_POINT_RST;

  pair_result_t expected_pairs[$];
  pair_result_t want;
  pair_result_t got;

  int errors         = 0;
  int items_sent     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int idle_cycles    = 0;

  radius_pair_finder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out the result beats that one accepted input beat causes.
  task predict_pairs(input logic [CMD_W-1:0] cmd, input logic signed [15:0] x,
                     input logic signed [15:0] y, input logic signed [15:0] z);
    int           j;
    int           hits;
    longint       dx, dy, dz, sqd;
    pair_result_t r;
    case (cmd)
      CMD_START: begin
        tgt_count   = 0;
        frame_lines = 0;
      end
      CMD_LOAD: begin
        // A full store ignores further loads.
        if (tgt_count < TGT_DEPTH) begin
          tgt_x[tgt_count] = x;
          tgt_y[tgt_count] = y;
          tgt_z[tgt_count] = z;
          tgt_count++;
        end
      end
      CMD_QUERY: begin
        hits = 0;
        for (j = 0; j < tgt_count; j++) begin
          if (frame_lines < max_lines_r && hits < max_per_point_r) begin
            dx  = longint'(tgt_x[j]) - longint'(x);
            dy  = longint'(tgt_y[j]) - longint'(y);
            dz  = longint'(tgt_z[j]) - longint'(z);
            sqd = dx * dx + dy * dy + dz * dz;
            if (sqd < longint'(dist_max_r)) begin
              r.is_end      = 1'b0;
              r.qx          = x;
              r.qy          = y;
              r.qz          = z;
              r.tx          = tgt_x[j];
              r.ty          = tgt_y[j];
              r.tz          = tgt_z[j];
              r.sq_dist     = sqd[DIST_W-1:0];
              r.match_count = '0;
              r.total_lines = '0;
              expected_pairs.push_back(r);
              hits++;
              frame_lines++;
            end
          end
        end
        // Every query closes with a summary beat.
        r.is_end      = 1'b1;
        r.qx          = x;
        r.qy          = y;
        r.qz          = z;
        r.tx          = '0;
        r.ty          = '0;
        r.tz          = '0;
        r.sq_dist     = '0;
        r.match_count = hits[MC_W-1:0];
        r.total_lines = frame_lines[CAP_W-1:0];
        expected_pairs.push_back(r);
      end
      default: ;
    endcase
  endtask

  // Send one input beat, with random idle cycles ahead of it.
  task send_item(input logic [CMD_W-1:0] cmd, input logic signed [15:0] x,
                 input logic signed [15:0] y, input logic signed [15:0] z);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_pairs(cmd, x, y, z);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  // Stop sending, wait for every expected beat, then let extra cycles pass.
  task settle(input int extra);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Write one configuration register and update its shadow.
  task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_DIST_MAX:      dist_max_r      = val[DIST_W-1:0];
      CFG_MAX_LINES:     max_lines_r     = val[CAP_W-1:0];
      CFG_MAX_PER_POINT: max_per_point_r = val[CAP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 74; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 74; end
      IDLE_BOTH:     begin send_idle_pct = 11; recv_stall_pct = 11; end
      default: ;
    endcase
  endtask

  task apply_setting(input setting_t kind);
    case (kind)
      SET_WIDE_OPEN: begin
        write_reg(CFG_DIST_MAX, 34'h3_FFFF_FFFF);
        write_reg(CFG_MAX_LINES, 34'd65535);
        write_reg(CFG_MAX_PER_POINT, 34'd65535);
      end
      SET_RANDOM_SMALL: begin
        write_reg(CFG_DIST_MAX, CFG_W'($urandom_range(0, 32'h0100_0000)));
        write_reg(CFG_MAX_LINES, CFG_W'($urandom_range(0, 40)));
        write_reg(CFG_MAX_PER_POINT, CFG_W'($urandom_range(0, 40)));
      end
      SET_CLOSED: begin
        write_reg(CFG_DIST_MAX, 34'd0);
        write_reg(CFG_MAX_LINES, 34'd0);
        write_reg(CFG_MAX_PER_POINT, 34'd0);
      end
      SET_RANDOM_MID: begin
        write_reg(CFG_DIST_MAX, {2'b00, $urandom_range(32'h0001_0000, 32'h1000_0000)});
        write_reg(CFG_MAX_LINES, CFG_W'($urandom_range(0, 200)));
        write_reg(CFG_MAX_PER_POINT, CFG_W'($urandom_range(0, 33)));
      end
      default: ;
    endcase
  endtask

  // A coordinate near a center, wrapping at the field width.
  function automatic logic signed [15:0] near(input logic signed [15:0] center,
                                              input int spread);
    int off;
    off  = int'($urandom_range(0, 2 * spread)) - spread;
    near = center + off[15:0];
  endfunction

  // Defaults after reset: empty store, unused command, boundary distances, extremes.
  task test_reset_defaults();
    send_item(CMD_QUERY, 16'sd0, 16'sd0, 16'sd0);
    send_item(CMD_UNUSED, -16'sd32768, 16'sd32767, -16'sd32768);
    send_item(CMD_START, 16'sd0, 16'sd0, 16'sd0);
    send_item(CMD_LOAD, 16'sd0, 16'sd0, 16'sd0);
    send_item(CMD_LOAD, 16'sd256, 16'sd0, 16'sd0);
    send_item(CMD_LOAD, 16'sd255, 16'sd0, 16'sd0);
    send_item(CMD_LOAD, -16'sd32768, -16'sd32768, -16'sd32768);
    send_item(CMD_LOAD, 16'sd32767, 16'sd32767, 16'sd32767);
    send_item(CMD_QUERY, 16'sd0, 16'sd0, 16'sd0);
    send_item(CMD_QUERY, -16'sd32768, -16'sd32768, -16'sd32768);
    send_item(CMD_QUERY, 16'sd32767, 16'sd32767, 16'sd32767);
    settle(0);
  endtask

  // Largest and smallest distance limit against the same stored set.
  task test_threshold_extremes();
    settle(DRAIN_CYCLES);
    write_reg(CFG_DIST_MAX, 34'h3_FFFF_FFFF);
    send_item(CMD_QUERY, -16'sd32768, -16'sd32768, -16'sd32768);
    settle(DRAIN_CYCLES);
    write_reg(CFG_DIST_MAX, 34'd0);
    send_item(CMD_QUERY, 16'sd0, 16'sd0, 16'sd0);
    settle(DRAIN_CYCLES);
  endtask

  // Per-query cap, frame cap reached, then zero per-query cap.
  task test_caps();
    write_reg(CFG_DIST_MAX, 34'd65536);
    write_reg(CFG_MAX_LINES, 34'd3);
    write_reg(CFG_MAX_PER_POINT, 34'd2);
    send_item(CMD_START, 16'sd0, 16'sd0, 16'sd0);
    repeat (4) send_item(CMD_LOAD, 16'sd100, -16'sd100, 16'sd50);
    repeat (3) send_item(CMD_QUERY, 16'sd120, -16'sd90, 16'sd40);
    settle(DRAIN_CYCLES);
    write_reg(CFG_MAX_LINES, 34'd65535);
    write_reg(CFG_MAX_PER_POINT, 34'd0);
    send_item(CMD_START, 16'sd0, 16'sd0, 16'sd0);
    send_item(CMD_LOAD, 16'sd1, 16'sd2, 16'sd3);
    send_item(CMD_QUERY, 16'sd1, 16'sd2, 16'sd3);
    settle(DRAIN_CYCLES);
  endtask

  // Random command, any of the four codes.
  function automatic logic [CMD_W-1:0] CMD_CNT_NOISE();
    CMD_CNT_NOISE = CMD_W'($urandom_range(0, 3));
  endfunction

  // One random frame: mostly start, loads and queries around a center, some noise.
  task random_frame();
    logic signed [15:0] cx, cy, cz;
    int                 spread;
    int                 n_load;
    int                 n_query;
    int                 i;
    cx     = 16'($urandom);
    cy     = 16'($urandom);
    cz     = 16'($urandom);
    spread = 1 << $urandom_range(4, 12);
    n_load = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 34) : $urandom_range(0, 8);
    n_query = $urandom_range(1, 4);
    // Now and then the frame start is left out and the old store is reused.
    if ($urandom_range(0, 9) != 0)
      send_item(CMD_START, 16'($urandom), 16'($urandom), 16'($urandom));
    for (i = 0; i < n_load; i++) begin
      if ($urandom_range(0, 7) == 0)
        send_item(CMD_CNT_NOISE(), 16'($urandom), 16'($urandom), 16'($urandom));
      else
        send_item(CMD_LOAD, near(cx, spread), near(cy, spread), near(cz, spread));
    end
    for (i = 0; i < n_query; i++)
      send_item(CMD_QUERY, near(cx, spread), near(cy, spread), near(cz, spread));
    if ($urandom_range(0, 9) == 0) settle(0);
  endtask

  // Random frames over every idling pattern and several register settings.
  task test_random_traffic();
    int phase;
    int stop_at;
    for (phase = 0; phase < 8; phase++) begin
      settle(DRAIN_CYCLES);
      set_idling(idle_mode_t'(phase / 2));
      apply_setting(setting_t'(phase % 4));
      stop_at = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) random_frame();
    end
    set_idling(IDLE_NONE);
  endtask

  // Receiver side: ready is redrawn at every falling edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task check_field(input string name, input logic [63:0] exp_v, input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.is_end      = out_tlast;
      got.qx          = out_tdata[15:0];
      got.qy          = out_tdata[31:16];
      got.qz          = out_tdata[47:32];
      got.tx          = out_tdata[63:48];
      got.ty          = out_tdata[79:64];
      got.tz          = out_tdata[95:80];
      got.sq_dist     = out_tdata[129:96];
      got.match_count = out_tdata[135:130];
      got.total_lines = out_tdata[151:136];
      if (expected_pairs.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual tlast %b tdata %h",
                 $time, out_tlast, out_tdata);
        errors++;
      end else begin
        want = expected_pairs.pop_front();
        check_field("is_end", want.is_end, got.is_end);
        check_field("qx", want.qx, got.qx);
        check_field("qy", want.qy, got.qy);
        check_field("qz", want.qz, got.qz);
        check_field("tx", want.tx, got.tx);
        check_field("ty", want.ty, got.ty);
        check_field("tz", want.tz, got.tz);
        check_field("sq_dist", want.sq_dist, got.sq_dist);
        check_field("match_count", want.match_count, got.match_count);
        check_field("total_lines", want.total_lines, got.total_lines);
      end
    end
  end

  // Watchdog: too many cycles without any beat on either channel ends the run.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_MAX) begin
      $display("%0t: watchdog, no beat for %0d cycles", $time, idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_threshold_extremes();
    test_caps();
    test_random_traffic();
    settle(DRAIN_CYCLES);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
